>>> sv/hke3d_pkg.sv
// Shared types, seed tables and the constant Hilbert transition table.
package hke3d_pkg;

    localparam int KEY_W     = 64;
    localparam int DEPTH_W   = 5;
    localparam int CORNER_W  = 2;
    localparam int AXIS_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_DEPTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CORNER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATH_AXIS    = 2'd2;

    // Reset values.
    localparam logic [DEPTH_W-1:0]  RST_KEY_DEPTH    = 5'd21;
    localparam logic [CORNER_W-1:0] RST_START_CORNER = 2'd0;
    localparam logic [AXIS_W-1:0]   RST_PATH_AXIS    = 2'd0;

    // Walk state carried between levels.
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [CORNER_W-1:0] sc;
        logic [AXIS_W-1:0]   ax;
    } t_walk;

    // Table entry: {digit[2:0], next corner[1:0], next axis[1:0]}, index {sc, ax, oct}.
    localparam int LUT_IDX_W = CORNER_W + AXIS_W + 3;
    localparam int LUT_ENT_W = 3 + CORNER_W + AXIS_W;
    typedef logic [(1 << LUT_IDX_W)-1:0][LUT_ENT_W-1:0] t_lut;

    localparam logic [2:0] CORNER_MASK [4] = '{3'd0, 3'd3, 3'd5, 3'd6};
    localparam logic [1:0] MASK_TO_CORNER [8] =
        '{2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd2, 2'd3, 2'd0};
    localparam logic [2:0] AXIS_MASK [3] = '{3'd4, 3'd2, 3'd1};
    localparam logic [1:0] BIG_STEP [3][8] = '{
        '{2'd1, 2'd2, 2'd1, 2'd0, 2'd1, 2'd2, 2'd1, 2'd0},
        '{2'd0, 2'd2, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd1},
        '{2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd1, 2'd0, 2'd2}
    };
    localparam logic [1:0] LITTLE_STEP [3][8] = '{
        '{2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd2, 2'd2, 2'd1},
        '{2'd0, 2'd2, 2'd2, 2'd1, 2'd1, 2'd2, 2'd2, 2'd0},
        '{2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0}
    };

    // Elaboration-time table build. Axis code 3 rows mirror axis code 2.
    function automatic t_lut f_build_lut();
        t_lut       lut;
        logic [2:0] oct;
        logic [2:0] cm;
        logic [2:0] bm;
        logic [2:0] lm;
        lut = '0;
        for (int ax = 0; ax < 3; ax++) begin
            for (int sc = 0; sc < 4; sc++) begin
                oct = CORNER_MASK[sc];
                cm  = CORNER_MASK[sc];
                for (int j = 0; j < 8; j++) begin
                    bm = AXIS_MASK[BIG_STEP[ax][j]];
                    lm = AXIS_MASK[LITTLE_STEP[ax][j]];
                    lut[{2'(sc), 2'(ax), oct}] =
                        {3'(j), MASK_TO_CORNER[cm], LITTLE_STEP[ax][j]};
                    oct = oct ^ bm;
                    cm  = cm ^ (bm ^ lm);
                end
            end
        end
        for (int sc = 0; sc < 4; sc++) begin
            for (int o = 0; o < 8; o++) begin
                lut[{2'(sc), 2'd3, 3'(o)}] = lut[{2'(sc), 2'd2, 3'(o)}];
            end
        end
        return lut;
    endfunction

    localparam t_lut HILBERT_LUT = f_build_lut();

endpackage

>>> sv/hilbert_key_encoder_3d_top.sv
// 3D Peano-Hilbert key encoder: pipelined level walk over a constant transition table.
//
// Usage:
//   Input channel: i_valid / o_stall with i_coord_x, i_coord_y, i_coord_z.
//   A transaction is taken at a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with o_spatial_key, one key per input.
//   Configuration: i_cfg_we, i_cfg_index, i_cfg_data; 0 = key_depth,
//   1 = start_corner, 2 = path_axis. Write only while the pipeline is empty.
// Pipeline: each stage resolves three levels, with three table lookups
//   chained per stage. Throughput: one transaction per cycle while the output is not stalled.
// Key: a leading 1, then one 3-bit digit per level from bit key_depth-1 down;
//   levels at or above key_depth pass the walk state through unchanged, so a
//   depth above COORD_BITS saturates on its own and depth 0 gives key 1.
// Reset: synchronous active low; empties the pipeline and restores
//   key_depth = 21, start_corner = 0, path_axis = 0.
// Stall: when the last stage holds a key and i_stall is high the whole
//   pipeline freezes and o_stall rises; nothing is dropped or repeated.
module hilbert_key_encoder_3d_top #(
    parameter int COORD_BITS = 21
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [hke3d_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hke3d_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    // input channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [COORD_BITS-1:0]                i_coord_x,
    input  logic [COORD_BITS-1:0]                i_coord_y,
    input  logic [COORD_BITS-1:0]                i_coord_z,
    // output channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [hke3d_pkg::KEY_W-1:0]          o_spatial_key
);

    // Levels resolved per pipeline stage and the resulting stage count.
    localparam int LPS  = 3;
    localparam int NSTG = (COORD_BITS + LPS - 1) / LPS;
    // Coordinates are held for all stages except the last.
    localparam int CSTG = (NSTG > 1) ? NSTG - 1 : 1;

    // Configuration registers.
    logic [hke3d_pkg::DEPTH_W-1:0]  r_key_depth;
    logic [hke3d_pkg::CORNER_W-1:0] r_start_corner;
    logic [hke3d_pkg::AXIS_W-1:0]   r_path_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_depth    <= hke3d_pkg::RST_KEY_DEPTH;
            r_start_corner <= hke3d_pkg::RST_START_CORNER;
            r_path_axis    <= hke3d_pkg::RST_PATH_AXIS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hke3d_pkg::CFG_KEY_DEPTH:    r_key_depth    <= i_cfg_data;
                hke3d_pkg::CFG_START_CORNER: r_start_corner <= i_cfg_data[1:0];
                hke3d_pkg::CFG_PATH_AXIS:    r_path_axis    <= i_cfg_data[1:0];
                default: ;  // index beyond the register list: ignored
            endcase
        end
    end

    // Pipeline registers.
    logic [NSTG-1:0]          r_vld;
    hke3d_pkg::t_walk         r_walk [NSTG];
    logic [COORD_BITS-1:0]    r_x [CSTG];
    logic [COORD_BITS-1:0]    r_y [CSTG];
    logic [COORD_BITS-1:0]    r_z [CSTG];

    // Stage inputs and per-level walk nodes.
    hke3d_pkg::t_walk         w_walk [NSTG][LPS+1];
    logic [COORD_BITS-1:0]    c_x [NSTG];
    logic [COORD_BITS-1:0]    c_y [NSTG];
    logic [COORD_BITS-1:0]    c_z [NSTG];

    // Global advance: frozen only while the finished key waits.
    logic adv;
    assign adv     = !(r_vld[NSTG-1] && i_stall);
    assign o_stall = !adv;

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        if (s == 0) begin : g_head
            assign w_walk[0][0] = '{key: hke3d_pkg::KEY_W'(1),
                                    sc:  r_start_corner,
                                    ax:  r_path_axis};
            assign c_x[0] = i_coord_x;
            assign c_y[0] = i_coord_y;
            assign c_z[0] = i_coord_z;
        end else begin : g_body
            assign w_walk[s][0] = r_walk[s-1];
            assign c_x[s] = r_x[s-1];
            assign c_y[s] = r_y[s-1];
            assign c_z[s] = r_z[s-1];
        end

        for (genvar k = 0; k < LPS; k++) begin : g_lvl
            localparam int LV = COORD_BITS - 1 - (s * LPS + k);
            if (LV >= 0) begin : g_act
                logic [2:0]                       oct;
                logic [hke3d_pkg::LUT_ENT_W-1:0]  ent;
                hke3d_pkg::t_walk                 nxt;
                assign oct = {c_z[s][LV], c_y[s][LV], c_x[s][LV]};
                assign ent = hke3d_pkg::HILBERT_LUT[{w_walk[s][k].sc, w_walk[s][k].ax, oct}];
                always_comb begin
                    nxt = w_walk[s][k];
                    // only the low key_depth levels contribute a digit
                    if (hke3d_pkg::DEPTH_W'(LV) < r_key_depth) begin
                        nxt.key = {w_walk[s][k].key[hke3d_pkg::KEY_W-4:0], ent[6:4]};
                        nxt.sc  = ent[3:2];
                        nxt.ax  = ent[1:0];
                    end
                end
                assign w_walk[s][k+1] = nxt;
            end else begin : g_pad
                assign w_walk[s][k+1] = w_walk[s][k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (adv) begin
                r_vld[s] <= (s == 0) ? i_valid : r_vld[(s == 0) ? 0 : s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_walk[s] <= w_walk[s][LPS];
            end
        end

        if (s < NSTG - 1) begin : g_crd
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_x[s] <= c_x[s];
                    r_y[s] <= c_y[s];
                    r_z[s] <= c_z[s];
                end
            end
        end
    end

    assign o_valid       = r_vld[NSTG-1];
    assign o_spatial_key = r_walk[NSTG-1].key;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // An accepted transaction lands in the first stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted transaction missing from first stage");

    // A waiting key freezes every stage's valid bit.
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && i_stall) |=> $stable(r_vld))
        else $error("pipeline moved while output stalled");

    // Zero depth encodes no levels.
    a_zero_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_key_depth == '0)) |-> (o_spatial_key == hke3d_pkg::KEY_W'(1)))
        else $error("depth zero key is not one");

    // Full depth puts the leading one at the top level's position.
    a_full_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_key_depth >= hke3d_pkg::DEPTH_W'(COORD_BITS)))
        |-> o_spatial_key[3*COORD_BITS])
        else $error("leading key bit misplaced at full depth");

endmodule

>>> dv/hke3d_key_checker.sv
// Checker for the 3D Hilbert key encoder: tracks config writes, predicts keys, compares outputs.
module hke3d_key_checker #(
    parameter int COORD_BITS = 21
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [hke3d_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hke3d_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic [COORD_BITS-1:0]                i_coord_x,
    input  logic [COORD_BITS-1:0]                i_coord_y,
    input  logic [COORD_BITS-1:0]                i_coord_z,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic [hke3d_pkg::KEY_W-1:0]          i_spatial_key,
    output int                                   o_pending,
    output int                                   o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Seed tables; packed, so each list runs from the highest entry down to entry 0.
    localparam logic [3:0][2:0] CORNER_BITS    = {3'd6, 3'd5, 3'd3, 3'd0};
    localparam logic [7:0][1:0] CORNER_OF_MASK =
        {2'd0, 2'd3, 2'd2, 2'd0, 2'd1, 2'd0, 2'd0, 2'd0};
    localparam logic [2:0][2:0] AXIS_BIT       = {3'd1, 3'd2, 3'd4};
    localparam logic [2:0][7:0][1:0] BIG_MOVE = {
        {2'd2, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd1, 2'd0},
        {2'd1, 2'd0, 2'd2, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0},
        {2'd0, 2'd1, 2'd2, 2'd1, 2'd0, 2'd1, 2'd2, 2'd1}
    };
    localparam logic [2:0][7:0][1:0] LITTLE_MOVE = {
        {2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0},
        {2'd0, 2'd2, 2'd2, 2'd1, 2'd1, 2'd2, 2'd2, 2'd0},
        {2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd2, 2'd2, 2'd1}
    };

    logic [2:0] digit_lut  [4][3][8];
    logic [1:0] corner_lut [4][3][8];
    logic [1:0] axis_lut   [4][3][8];

    logic [hke3d_pkg::DEPTH_W-1:0]  cur_depth;
    logic [hke3d_pkg::CORNER_W-1:0] cur_corner;
    logic [hke3d_pkg::AXIS_W-1:0]   cur_axis;
    logic [hke3d_pkg::KEY_W-1:0]    key_q [$];
    int                             fail_count = 0;

    assign o_fail_count = fail_count;

    // Walk each (axis, corner) row along its curve order to fill the step tables.
    initial begin : build_walk_tables
        logic [2:0] oct;
        logic [2:0] cm;
        logic [2:0] bm;
        logic [2:0] lm;
        for (int ax = 0; ax < 3; ax++) begin
            for (int sc = 0; sc < 4; sc++) begin
                oct = CORNER_BITS[sc];
                cm  = CORNER_BITS[sc];
                for (int j = 0; j < 8; j++) begin
                    bm = AXIS_BIT[BIG_MOVE[ax][j]];
                    lm = AXIS_BIT[LITTLE_MOVE[ax][j]];
                    digit_lut[sc][ax][oct]  = 3'(j);
                    corner_lut[sc][ax][oct] = CORNER_OF_MASK[cm];
                    axis_lut[sc][ax][oct]   = LITTLE_MOVE[ax][j];
                    oct = oct ^ bm;
                    cm  = cm ^ (bm ^ lm);
                end
            end
        end
    end

    function automatic logic [hke3d_pkg::KEY_W-1:0] hilbert_key(
        input logic [COORD_BITS-1:0] cx,
        input logic [COORD_BITS-1:0] cy,
        input logic [COORD_BITS-1:0] cz
    );
        logic [hke3d_pkg::KEY_W-1:0] key;
        logic [1:0]                  corner;
        logic [1:0]                  axis;
        logic [1:0]                  nxt_corner;
        logic [1:0]                  nxt_axis;
        logic [2:0]                  oct;
        int                          levels;
        key    = hke3d_pkg::KEY_W'(1);
        corner = cur_corner;
        axis   = (cur_axis == 2'd3) ? 2'd2 : cur_axis;   // code 3 walks as code 2
        levels = (int'(cur_depth) > COORD_BITS) ? COORD_BITS : int'(cur_depth);
        for (int lvl = levels - 1; lvl >= 0; lvl--) begin
            oct        = {cz[lvl], cy[lvl], cx[lvl]};
            key        = {key[hke3d_pkg::KEY_W-4:0], digit_lut[corner][axis][oct]};
            nxt_corner = corner_lut[corner][axis][oct];
            nxt_axis   = axis_lut[corner][axis][oct];
            corner     = nxt_corner;
            axis       = nxt_axis;
        end
        return key;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        logic [hke3d_pkg::KEY_W-1:0] exp_key;
        if (!i_rst_n) begin
            cur_depth  <= hke3d_pkg::RST_KEY_DEPTH;
            cur_corner <= hke3d_pkg::RST_START_CORNER;
            cur_axis   <= hke3d_pkg::RST_PATH_AXIS;
            key_q.delete();
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    hke3d_pkg::CFG_KEY_DEPTH:    cur_depth  <= i_cfg_data;
                    hke3d_pkg::CFG_START_CORNER: cur_corner <= i_cfg_data[1:0];
                    hke3d_pkg::CFG_PATH_AXIS:    cur_axis   <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                key_q.push_back(hilbert_key(i_coord_x, i_coord_y, i_coord_z));
            end
            if (i_out_valid && !i_out_stall) begin
                if (key_q.size() == 0) begin
                    $error("spatial_key: expected no transaction, actual %h", i_spatial_key);
                    fail_count++;
                end else begin
                    exp_key = key_q.pop_front();
                    if (i_spatial_key !== exp_key) begin
                        $error("spatial_key: expected %h, actual %h", exp_key, i_spatial_key);
                        fail_count++;
                    end
                end
            end
        end
        o_pending = key_q.size();
    end

endmodule

>>> dv/hilbert_key_encoder_3d_top_test.sv
// Testbench top: drives coordinates, config writes and output back-pressure, gives the verdict.
module hilbert_key_encoder_3d_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS = 21;
    localparam int N_ITEMS    = 400;
    localparam int N_PHASES   = 8;
    localparam int LONG_HOLD  = 60;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_we;
    logic [hke3d_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [hke3d_pkg::CFG_DAT_W-1:0]   cfg_data;
    logic                              in_valid;
    logic                              in_stall;
    logic [COORD_BITS-1:0]             coord_x;
    logic [COORD_BITS-1:0]             coord_y;
    logic [COORD_BITS-1:0]             coord_z;
    logic                              out_valid;
    logic                              out_stall;
    logic [hke3d_pkg::KEY_W-1:0]       spatial_key;
    int                                pending;
    int                                fail_count;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    hilbert_key_encoder_3d_top #(
        .COORD_BITS(COORD_BITS)
    ) u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_valid      (in_valid),
        .o_stall      (in_stall),
        .i_coord_x    (coord_x),
        .i_coord_y    (coord_y),
        .i_coord_z    (coord_z),
        .o_valid      (out_valid),
        .i_stall      (out_stall),
        .o_spatial_key(spatial_key)
    );

    hke3d_key_checker #(
        .COORD_BITS(COORD_BITS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_coord_x    (coord_x),
        .i_coord_y    (coord_y),
        .i_coord_z    (coord_z),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_spatial_key(spatial_key),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Returns at a rising edge once every accepted transaction has left the block.
    task automatic wait_drained();
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic cfg_write(
        input logic [hke3d_pkg::CFG_IDX_W-1:0] idx,
        input logic [hke3d_pkg::CFG_DAT_W-1:0] dat
    );
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= dat;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly random coordinates, with all-zero and all-one corners mixed in.
    function automatic logic [COORD_BITS-1:0] rand_coord();
        logic [COORD_BITS-1:0] v;
        v = COORD_BITS'($urandom());
        if ($urandom_range(0, 15) == 0) begin
            v = '0;
        end else if ($urandom_range(0, 15) == 0) begin
            v = '1;
        end
        return v;
    endfunction

    initial begin : stimulus
        int                            gap;
        logic [hke3d_pkg::DEPTH_W-1:0] depth;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        coord_x   <= '0;
        coord_y   <= '0;
        coord_z   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // first phase runs on the reset configuration
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph != 0) begin
                wait_drained();
                if (ph == 1) begin
                    depth = '0;
                end else if (ph == 2) begin
                    depth = '1;     // above COORD_BITS, saturates
                end else if (ph == 3) begin
                    depth = hke3d_pkg::DEPTH_W'(1);
                end else begin
                    depth = hke3d_pkg::DEPTH_W'($urandom_range(0, 31));
                end
                cfg_write(hke3d_pkg::CFG_KEY_DEPTH, depth);
                cfg_write(hke3d_pkg::CFG_START_CORNER,
                          hke3d_pkg::CFG_DAT_W'($urandom_range(0, 3)));
                cfg_write(hke3d_pkg::CFG_PATH_AXIS,
                          hke3d_pkg::CFG_DAT_W'($urandom_range(0, 3)));
            end
            for (int n = 0; n < N_ITEMS / N_PHASES; n++) begin
                if ($urandom_range(0, 15) == 0) begin
                    gap = $urandom_range(10, 40);
                end else begin
                    gap = $urandom_range(0, 2);
                end
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                in_valid <= 1'b1;
                coord_x  <= rand_coord();
                coord_y  <= rand_coord();
                coord_z  <= rand_coord();
                @(posedge clk);
                while (in_stall) @(posedge clk);
            end
            in_valid <= 1'b0;
        end
        wait_drained();
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Receiver back-pressure: short random stalls, a few long ones, and two
    // long holds while the sender is busy so the pipeline fills up.
    initial begin : receiver
        int cyc;
        int hold;
        int holds_done;
        out_stall <= 1'b0;
        cyc        = 0;
        holds_done = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            cyc++;
            if (((holds_done == 0 && cyc >= 100) || (holds_done == 1 && cyc >= 600))
                && in_valid) begin
                out_stall <= 1'b1;
                hold = 0;
                while (hold < LONG_HOLD) begin
                    @(posedge clk);
                    hold++;
                end
                cyc += hold;
                holds_done++;
                out_stall <= 1'b0;
            end else if ($urandom_range(0, 19) == 0) begin
                out_stall <= 1'b1;
                hold = $urandom_range(8, 30);
                repeat (hold) @(posedge clk);
                cyc += hold;
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial begin : watchdog
        #2000000;
        $error("run did not finish in time");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
